/* hdl/sha512_stream_hasher_assert.svh */
// Assertion macros for the SHA-512 stream hasher.
// Included by the top level; no other dependencies.
`ifndef SHA512_STREAM_HASHER_ASSERT_SVH
`define SHA512_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/sha512_pkg.sv */
// Shared types, constants and round functions for the SHA-512 stream hasher.
// No dependencies.
package sha512_pkg;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Command from the front end to the compression engine.
    typedef struct packed {
        logic [1023:0] block;
        logic          last;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PAD,
        FS_LEN,
        FS_WAIT
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ROUND,
        BS_ADD,
        BS_EMIT
    } t_back_state;

    localparam int BLOCK_BYTES = 128;
    localparam int LEN_OFFSET  = 112;
    localparam int ROUNDS      = 80;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [511:0] INIT_HASH = {
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    function automatic logic [63:0] round_const(input logic [6:0] t);
        logic [63:0] k;
        begin
            case (t)
                7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
                default: k = 64'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

endpackage

/* hdl/sha512_front.sv */
// Front end: collects message bytes into blocks, pads at finish and issues
// compression jobs. Depends on sha512_pkg.
module sha512_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sha512_pkg::t_in_item  i_item,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output sha512_pkg::t_job      o_job
);
    import sha512_pkg::*;

    t_front_state  r_state, n_state;
    logic [1023:0] r_block, n_block;
    logic [6:0]    r_fill, n_fill;
    logic [124:0]  r_total, n_total;
    logic          r_jv, n_jv;
    t_job          r_job, n_job;

    logic [127:0] w_bits;
    assign w_bits = {r_total, 3'b000};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_fill  <= '0;
            r_total <= '0;
            r_jv    <= 1'b0;
            r_block <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_jv    <= n_jv;
            r_block <= n_block;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // Byte collection and padding sequencer.
    always_comb begin
        n_state = r_state;
        n_block = r_block;
        n_fill  = r_fill;
        n_total = r_total;
        n_jv    = r_jv;
        n_job   = r_job;
        o_ready = 1'b0;
        if (r_jv && i_job_ready) begin
            n_jv = 1'b0;
        end
        case (r_state)
            FS_IDLE: begin
                o_ready = !n_jv;
                if (i_valid && o_ready) begin
                    if (i_item.operation == OP_APPEND) begin
                        n_block[1023 - 8*r_fill -: 8] = i_item.data_byte;
                        n_total = r_total + 125'd1;
                        if (r_fill == 7'd127) begin
                            n_job.block = n_block;
                            n_job.last  = 1'b0;
                            n_jv        = 1'b1;
                            n_block     = '0;
                            n_fill      = '0;
                        end else begin
                            n_fill = r_fill + 7'd1;
                        end
                    end else begin
                        n_block[1023 - 8*r_fill -: 8] = PAD_BYTE;
                        if (r_fill >= 7'(LEN_OFFSET)) begin
                            n_job.block = n_block;
                            n_job.last  = 1'b0;
                            n_jv        = 1'b1;
                            n_block     = '0;
                        end
                        n_state = FS_LEN;
                    end
                end
            end
            FS_LEN: begin
                if (!n_jv) begin
                    n_job.block = {r_block[1023:128], w_bits};
                    n_job.last  = 1'b1;
                    n_jv        = 1'b1;
                    n_block     = '0;
                    n_fill      = '0;
                    n_total     = '0;
                    n_state     = FS_WAIT;
                end
            end
            FS_WAIT: begin
                if (!n_jv) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_job_valid = r_jv;
    assign o_job       = r_job;

endmodule

/* hdl/sha512_back.sv */
// Back end: 80-round SHA-512 compression, chaining update and digest output.
// Depends on sha512_pkg.
module sha512_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    output logic                   o_job_ready,
    input  sha512_pkg::t_job       i_job,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sha512_pkg::t_out_item  o_item
);
    import sha512_pkg::*;

    t_back_state    r_state, n_state;
    logic [511:0]   r_hash, n_hash;
    logic [63:0]    r_v [8];
    logic [63:0]    n_v [8];
    logic [63:0]    r_w [16];
    logic [63:0]    n_w [16];
    logic [6:0]     r_rnd, n_rnd;
    logic           r_last, n_last;
    logic [2:0]     r_idx, n_idx;

    logic [63:0] w_wt, w_s0, w_s1, w_t1, w_t2, w_ch, w_maj, w_e0, w_e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_hash  <= INIT_HASH;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_rnd   <= n_rnd;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

    // Message schedule: window shifts one word per round, w[0] is current.
    always_comb begin
        w_s0 = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        w_s1 = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_wt = r_w[0];
        w_e1 = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
        w_ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1 = r_v[7] + w_e1 + w_ch + round_const(r_rnd) + w_wt;
        w_e0 = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[1] & r_v[2]) ^ (r_v[2] & r_v[0]);
        w_t2 = w_e0 + w_maj;
    end

    // Round sequencer and digest emission.
    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        n_v     = r_v;
        n_w     = r_w;
        n_rnd   = r_rnd;
        n_last  = r_last;
        n_idx   = r_idx;
        o_job_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            BS_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    for (int k = 0; k < 8; k++) begin
                        n_v[k] = r_hash[511 - 64*k -: 64];
                    end
                    for (int k = 0; k < 16; k++) begin
                        n_w[k] = i_job.block[1023 - 64*k -: 64];
                    end
                    n_last  = i_job.last;
                    n_rnd   = '0;
                    n_state = BS_ROUND;
                end
            end
            BS_ROUND: begin
                n_v[7] = r_v[6]; n_v[6] = r_v[5]; n_v[5] = r_v[4];
                n_v[4] = r_v[3] + w_t1;
                n_v[3] = r_v[2]; n_v[2] = r_v[1]; n_v[1] = r_v[0];
                n_v[0] = w_t1 + w_t2;
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k + 1];
                end
                n_w[15] = r_w[0] + w_s0 + r_w[9] + w_s1;
                if (r_rnd == 7'(ROUNDS - 1)) begin
                    n_state = BS_ADD;
                end else begin
                    n_rnd = r_rnd + 7'd1;
                end
            end
            BS_ADD: begin
                for (int k = 0; k < 8; k++) begin
                    n_hash[511 - 64*k -: 64] = r_hash[511 - 64*k -: 64] + r_v[k];
                end
                n_idx   = '0;
                n_state = r_last ? BS_EMIT : BS_IDLE;
            end
            BS_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_hash  = INIT_HASH;
                        n_state = BS_IDLE;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    assign o_item.digest_word = r_hash[511 - 64*r_idx -: 64];
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = (r_idx == 3'd7);

endmodule

/* hdl/sha512_stream_hasher.sv */
// SHA-512 stream hasher: top level joining front end and compression engine.
// Depends on sha512_pkg, sha512_front, sha512_back and the assertion header.
//
// Usage: the input channel (i_valid/o_ready, i_item) carries one transaction
// per message byte (operation append) or a finish transaction. Appends are
// taken one per cycle until a 128-byte block is full; that block is handed
// to the compression engine through a one-entry job register, and the front
// end keeps collecting the next block while the engine runs. The engine does
// one round per cycle; a block passes through load, 80 rounds and add. The
// front end stalls while a full block waits in the job register for the
// engine to take it, and after a finish while in FS_LEN and FS_WAIT.
// A finish pads the message (one or two blocks) and the digest then leaves
// on the output channel (o_valid/i_ready, o_item) as eight transactions,
// word 0 first, one per cycle when the receiver is ready. When the
// receiver stalls the current word holds; no new finish completes until
// all eight words are taken. Synchronous reset restores the initial hash
// value and empties the block and byte count.
`include "sha512_stream_hasher_assert.svh"
module sha512_stream_hasher (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  sha512_pkg::t_in_item   i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output sha512_pkg::t_out_item  o_item
);
    import sha512_pkg::*;

    logic w_job_valid, w_job_ready;
    t_job w_job;

    sha512_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    sha512_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

    // Digest words leave in order.
    `SHA_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_item.last_word, o_item.word_index == $past(o_item.word_index) + 3'd1)
    // A stalled digest word holds.
    `SHA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item))
    // Digest output never overlaps an accepted job.
    `SHA_ASSERT_IMP(a_no_job_emit, i_clk, i_rst_n, o_valid, !w_job_ready)

endmodule

/* tb/sha512_digest_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the SHA-512 stream hasher: watches both channels, computes the digest.
// Depends on sha512_pkg for the transaction types and the hash constants.
module sha512_digest_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  sha512_pkg::t_in_item  i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  sha512_pkg::t_out_item i_out_item,
    output int                    o_fail_count,
    output int                    o_pending
);
    import sha512_pkg::*;

    logic [63:0]  hash_state [8];
    logic [7:0]   msg_block [BLOCK_BYTES];
    int unsigned  fill;
    logic [124:0] byte_count;
    t_out_item    digest_queue [$];

    function automatic logic [63:0] ror64(input logic [63:0] x, input int s);
        return (x >> s) | (x << (64 - s));
    endfunction

    function automatic void restart_message();
        for (int k = 0; k < 8; k++) hash_state[k] = INIT_HASH[511 - 64 * k -: 64];
        for (int k = 0; k < BLOCK_BYTES; k++) msg_block[k] = 8'h00;
        fill = 0;
        byte_count = '0;
    endfunction

    // Eighty rounds over the held block, add into the hash state, then clear it for the next one.
    function automatic void compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, a15, a2, s0, s1, t1, t2;
        for (int k = 0; k < 8; k++) v[k] = hash_state[k];
        for (int t = 0; t < ROUNDS; t++) begin
            if (t < 16) begin
                wt = '0;
                for (int k = 0; k < 8; k++) wt = {wt[55:0], msg_block[t * 8 + k]};
            end else begin
                a15 = w[(t - 15) & 15];
                a2  = w[(t - 2) & 15];
                s0 = ror64(a15, 1) ^ ror64(a15, 8) ^ (a15 >> 7);
                s1 = ror64(a2, 19) ^ ror64(a2, 61) ^ (a2 >> 6);
                wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
            end
            w[t & 15] = wt;
            s1 = ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t[6:0]) + wt;
            s0 = ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39);
            t2 = s0 + ((v[0] & v[1]) ^ (v[1] & v[2]) ^ (v[2] & v[0]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_state[k] += v[k];
        for (int k = 0; k < BLOCK_BYTES; k++) msg_block[k] = 8'h00;
        fill = 0;
    endfunction

    // Pad with the marker byte and the bit length, then queue the eight words.
    function automatic void finish_message();
        logic [127:0] bit_len;
        t_out_item    word;
        msg_block[fill] = PAD_BYTE;
        fill++;
        if (fill > LEN_OFFSET) compress_block();
        bit_len = {byte_count, 3'b000};
        for (int k = 0; k < 16; k++) msg_block[LEN_OFFSET + k] = bit_len[127 - 8 * k -: 8];
        compress_block();
        for (int k = 0; k < 8; k++) begin
            word.digest_word = hash_state[k];
            word.word_index  = k[2:0];
            word.last_word   = (k == 7);
            digest_queue.push_back(word);
        end
        restart_message();
    endfunction

    function automatic void report(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s expected %h actual %h", $realtime, what, exp_v, act_v);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        restart_message();
    end

    // Input transactions drive the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && i_in_ready) begin
            if (i_in_item.operation == OP_APPEND) begin
                msg_block[fill] = i_in_item.data_byte;
                fill++;
                byte_count++;
                if (fill == BLOCK_BYTES) compress_block();
            end else begin
                finish_message();
            end
            o_pending = digest_queue.size();
        end
    end

    // Each output transaction is compared with the oldest predicted word.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (digest_queue.size() == 0) begin
                report("unexpected digest word", '0, i_out_item.digest_word);
            end else begin
                want = digest_queue.pop_front();
                if (i_out_item.digest_word !== want.digest_word)
                    report("digest_word", want.digest_word, i_out_item.digest_word);
                if (i_out_item.word_index !== want.word_index)
                    report("word_index", want.word_index, i_out_item.word_index);
                if (i_out_item.last_word !== want.last_word)
                    report("last_word", want.last_word, i_out_item.last_word);
            end
            o_pending = digest_queue.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the SHA-512 stream hasher: clock, reset, stimulus and verdict.
// Depends on sha512_pkg, the hasher RTL and sha512_digest_checker.
module tb;
    import sha512_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;
    int        fail_count;
    int        words_pending;
    int        stall_cycles;
    bit        tx_idle_en;
    bit        rx_idle_en;

    sha512_stream_hasher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    sha512_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random idling, plus a long hold-off when one is requested.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_cycles > 0) begin
                i_ready <= 1'b0;
                stall_cycles--;
            end else begin
                i_ready <= !(rx_idle_en && $urandom_range(99) < 10);
            end
        end
    end

    // Offer one transaction and hold it until accepted, then maybe idle.
    task automatic send_item(input t_op op, input logic [7:0] data);
        i_valid <= 1'b1;
        i_item  <= '{operation: op, data_byte: data};
        do @(posedge i_clk); while (!o_ready);
        if (tx_idle_en && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic hash_random_message(input int length);
        for (int i = 0; i < length; i++) send_item(OP_APPEND, 8'($urandom));
        send_item(OP_FINISH, 8'($urandom));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_item       = '0;
        stall_cycles = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, "abc", extreme byte values.
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_APPEND, 8'h61);
        send_item(OP_APPEND, 8'h62);
        send_item(OP_APPEND, 8'h63);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_FINISH, 8'h5A);

        // A stretch with no idling on either side; the tail needs an extra block.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hash_random_message(112);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Receiver holds off while the sender keeps offering finishes.
        stall_cycles = 700;
        hash_random_message(3);
        hash_random_message(0);
        hash_random_message(1);

        // Sender waits until every digest word has drained.
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (words_pending == 0);
        @(posedge i_clk);

        for (int m = 0; m < 2; m++) hash_random_message($urandom_range(0, 12));
        i_valid <= 1'b0;
        @(posedge i_clk);

        wait (words_pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
